// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; include guarded
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/scs_pkg.sv -----
// shared types and constants for the shortest common supersequence block
// no dependencies
`timescale 1ns / 1ps

package scs_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int SYM_W       = 8;
    localparam int CMD_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    typedef logic [SYM_W-1:0] sym_t;

endpackage

// ----- sv/scs_str_mem.sv -----
// symbol buffer for one input string: one write port, one registered read port
// depends on scs_pkg
`timescale 1ns / 1ps

module scs_str_mem #(
    parameter int DEPTH = scs_pkg::MAX_LEN_DEF,
    parameter int AW    = 5
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  scs_pkg::sym_t      wdata,
    input  logic [AW-1:0]      raddr,
    output scs_pkg::sym_t      rdata
);
    import scs_pkg::*;

    sym_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/scs_lcs_mem.sv -----
// lcs score memory: one write port, two registered read ports
// depends on scs_pkg
`timescale 1ns / 1ps

module scs_lcs_mem #(
    parameter int DEPTH = (scs_pkg::MAX_LEN_DEF + 1) * (scs_pkg::MAX_LEN_DEF + 1),
    parameter int AW    = 11,
    parameter int DW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr0,
    output logic [DW-1:0] rdata0,
    input  logic [AW-1:0] raddr1,
    output logic [DW-1:0] rdata1
);
    import scs_pkg::*;

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ----- sv/scs_res_mem.sv -----
// traceback result buffer, filled last symbol first, read back in reverse
// depends on scs_pkg
`timescale 1ns / 1ps

module scs_res_mem #(
    parameter int DEPTH = 2 * scs_pkg::MAX_LEN_DEF,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  scs_pkg::sym_t wdata,
    input  logic [AW-1:0] raddr,
    output scs_pkg::sym_t rdata
);
    import scs_pkg::*;

    sym_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/shortest_common_supersequence.sv -----
// Shortest common supersequence of two byte strings. Load items (command 0 or 1)
// append one symbol to the first or second string buffer, up to MAX_LEN symbols
// each; a load into a full buffer is dropped and raises the overflow mark shown on
// the results of the next compute. Loads are accepted back to back while no compute
// is running. A compute item (command 2) fills the lcs score table row by row when
// neither string is empty, then traces back from the far corner into a result
// buffer, then emits the result items first to last with last set on the final
// one; both buffers and the overflow mark are cleared. Two empty strings give one
// item with empty_res set. Every step reads a memory through its registered read
// port before acting on the data: a fill step then compares and writes the score
// back, a traceback step writes one symbol to the result buffer, and an emit step
// loads the output register, waiting while the output is stalled.
// Command 3 is ignored. Input stall is high for the whole of a compute.
// depends on scs_pkg, scs_str_mem, scs_lcs_mem, scs_res_mem
`timescale 1ns / 1ps

module shortest_common_supersequence #(
    parameter int MAX_LEN = scs_pkg::MAX_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [scs_pkg::CMD_W-1:0]  command,
    input  logic [scs_pkg::SYM_W-1:0]  symbol,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [scs_pkg::SYM_W-1:0]  symbol_out,
    output logic                       last,
    output logic                       empty_res,
    output logic                       overflow
);
    import scs_pkg::*;

    // widths all follow from MAX_LEN
    localparam int LEN_W   = $clog2(MAX_LEN + 1);             // length 0..MAX_LEN
    localparam int STR_AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DIM     = MAX_LEN + 1;
    localparam int LCS_DEP = DIM * DIM;
    localparam int LCS_AW  = $clog2(LCS_DEP);
    localparam int VAL_W   = LEN_W;                           // score 0..MAX_LEN
    localparam int RES_DEP = 2 * MAX_LEN;
    localparam int RES_AW  = $clog2(RES_DEP);
    localparam int K_W     = $clog2(RES_DEP + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL_RD,
        S_FILL_WR,
        S_TR_RD,
        S_TR_WR,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMPTY
    } state_t;

    // row-major score address, borders never stored (read back as zero)
    function automatic logic [LCS_AW-1:0] lcs_addr(input logic [LEN_W-1:0] r,
                                                   input logic [LEN_W-1:0] c);
        return LCS_AW'(int'(r) * DIM + int'(c));
    endfunction

    state_t             state_reg;
    logic [LEN_W-1:0]   len_a_reg;
    logic [LEN_W-1:0]   len_b_reg;
    logic               dropped_reg;
    logic [LEN_W-1:0]   n_reg;
    logic [LEN_W-1:0]   m_reg;
    logic               ovf_reg;
    logic [LEN_W-1:0]   r_reg;
    logic [LEN_W-1:0]   c_reg;
    logic [VAL_W-1:0]   left_reg;       // score of the cell to the left
    logic [VAL_W-1:0]   diag_reg;       // up score of the previous column
    logic [K_W-1:0]     k_reg;
    logic [RES_AW-1:0]  idx_reg;

    logic               out_valid_reg;
    sym_t               out_sym_reg;
    logic               out_last_reg;
    logic               out_empty_reg;
    logic               out_ovf_reg;

    // memory ports
    logic               a_we;
    logic               b_we;
    logic [STR_AW-1:0]  a_waddr;
    logic [STR_AW-1:0]  b_waddr;
    logic [STR_AW-1:0]  a_raddr;
    logic [STR_AW-1:0]  b_raddr;
    sym_t               a_rdata;
    sym_t               b_rdata;
    logic               lcs_we;
    logic [LCS_AW-1:0]  lcs_waddr;
    logic [VAL_W-1:0]   lcs_wdata;
    logic [LCS_AW-1:0]  lcs_raddr0;
    logic [LCS_AW-1:0]  lcs_raddr1;
    logic [VAL_W-1:0]   lcs_rdata0;
    logic [VAL_W-1:0]   lcs_rdata1;
    logic               res_we;
    sym_t               res_wdata;
    sym_t               res_rdata;

    // handshake
    logic               in_fire;
    logic               slot_free;
    logic               out_load;
    logic [LEN_W-1:0]   r_m1;
    logic [LEN_W-1:0]   c_m1;

    // datapath values
    logic [VAL_W-1:0]   up_val;
    logic [VAL_W-1:0]   left_val;
    logic [VAL_W-1:0]   diag_val;
    logic [VAL_W-1:0]   cell_val;
    logic               sym_eq;
    logic               take_a;
    logic               dec_r;
    logic               dec_c;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    // a new result item enters the output register this cycle
    assign out_load  = slot_free && ((state_reg == S_EMIT_LD) || (state_reg == S_EMPTY));

    // guarded index minus one; a zero index stays zero instead of wrapping
    assign r_m1 = (r_reg == '0) ? '0 : r_reg - LEN_W'(1);
    assign c_m1 = (c_reg == '0) ? '0 : c_reg - LEN_W'(1);

    // loads write the string buffers only while idle
    assign a_we    = in_fire && (command == CMD_LOAD_A) && (len_a_reg < LEN_W'(MAX_LEN));
    assign b_we    = in_fire && (command == CMD_LOAD_B) && (len_b_reg < LEN_W'(MAX_LEN));
    assign a_waddr = len_a_reg[STR_AW-1:0];
    assign b_waddr = len_b_reg[STR_AW-1:0];
    assign a_raddr = r_m1[STR_AW-1:0];
    assign b_raddr = c_m1[STR_AW-1:0];

    // score reads: port 0 the cell above, port 1 the cell to the left
    assign lcs_raddr0 = lcs_addr(r_m1, c_reg);
    assign lcs_raddr1 = lcs_addr(r_reg, c_m1);
    assign lcs_waddr  = lcs_addr(r_reg, c_reg);
    assign lcs_we     = (state_reg == S_FILL_WR);

    // border cells read as zero
    assign up_val   = (r_reg == LEN_W'(1)) ? '0 : lcs_rdata0;
    assign sym_eq   = (a_rdata == b_rdata);

    // fill: left and diagonal come from the previous column of this row
    assign left_val = (c_reg == LEN_W'(1)) ? '0 : left_reg;
    assign diag_val = (c_reg == LEN_W'(1)) ? '0 : diag_reg;
    always_comb
    begin
        if (sym_eq)
        begin
            cell_val = diag_val + VAL_W'(1);
        end
        else if (up_val > left_val)
        begin
            cell_val = up_val;
        end
        else
        begin
            cell_val = left_val;
        end
    end
    assign lcs_wdata = cell_val;

    // traceback decision; left read comes from memory port 1
    always_comb
    begin
        take_a = 1'b0;
        dec_r  = 1'b0;
        dec_c  = 1'b0;
        if ((r_reg != '0) && (c_reg != '0))
        begin
            if (sym_eq)
            begin
                take_a = 1'b1;
                dec_r  = 1'b1;
                dec_c  = 1'b1;
            end
            else if (up_val > ((c_reg == LEN_W'(1)) ? VAL_W'(0) : lcs_rdata1))
            begin
                take_a = 1'b1;
                dec_r  = 1'b1;
            end
            else
            begin
                dec_c = 1'b1;
            end
        end
        else if (r_reg != '0)
        begin
            take_a = 1'b1;
            dec_r  = 1'b1;
        end
        else
        begin
            dec_c = 1'b1;
        end
    end
    assign res_we    = (state_reg == S_TR_WR);
    assign res_wdata = take_a ? a_rdata : b_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            dropped_reg   <= 1'b0;
            n_reg         <= '0;
            m_reg         <= '0;
            ovf_reg       <= 1'b0;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // result taken and nothing new to load, output slot empties
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (command == CMD_LOAD_A)
                        begin
                            if (a_we)
                            begin
                                len_a_reg <= len_a_reg + LEN_W'(1);
                            end
                            else
                            begin
                                dropped_reg <= 1'b1;
                            end
                        end
                        else if (command == CMD_LOAD_B)
                        begin
                            if (b_we)
                            begin
                                len_b_reg <= len_b_reg + LEN_W'(1);
                            end
                            else
                            begin
                                dropped_reg <= 1'b1;
                            end
                        end
                        else if (command == CMD_COMPUTE)
                        begin
                            n_reg       <= len_a_reg;
                            m_reg       <= len_b_reg;
                            ovf_reg     <= dropped_reg;
                            dropped_reg <= 1'b0;
                            len_a_reg   <= '0;
                            len_b_reg   <= '0;
                            k_reg       <= '0;
                            if ((len_a_reg == '0) && (len_b_reg == '0))
                            begin
                                state_reg <= S_EMPTY;
                            end
                            else if ((len_a_reg != '0) && (len_b_reg != '0))
                            begin
                                r_reg     <= LEN_W'(1);
                                c_reg     <= LEN_W'(1);
                                state_reg <= S_FILL_RD;
                            end
                            else
                            begin
                                // one string empty: the other is the answer
                                r_reg     <= len_a_reg;
                                c_reg     <= len_b_reg;
                                state_reg <= S_TR_RD;
                            end
                        end
                    end
                end

                S_FILL_RD:
                begin
                    state_reg <= S_FILL_WR;
                end

                S_FILL_WR:
                begin
                    left_reg <= cell_val;
                    diag_reg <= up_val;
                    if (c_reg == m_reg)
                    begin
                        if (r_reg == n_reg)
                        begin
                            // table done, trace from the far corner
                            state_reg <= S_TR_RD;
                        end
                        else
                        begin
                            r_reg     <= r_reg + LEN_W'(1);
                            c_reg     <= LEN_W'(1);
                            state_reg <= S_FILL_RD;
                        end
                    end
                    else
                    begin
                        c_reg     <= c_reg + LEN_W'(1);
                        state_reg <= S_FILL_RD;
                    end
                end

                S_TR_RD:
                begin
                    if ((r_reg == '0) && (c_reg == '0))
                    begin
                        idx_reg   <= RES_AW'(k_reg - K_W'(1));
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        state_reg <= S_TR_WR;
                    end
                end

                S_TR_WR:
                begin
                    k_reg <= k_reg + K_W'(1);
                    if (dec_r)
                    begin
                        r_reg <= r_reg - LEN_W'(1);
                    end
                    if (dec_c)
                    begin
                        c_reg <= c_reg - LEN_W'(1);
                    end
                    state_reg <= S_TR_RD;
                end

                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end

                S_EMIT_LD:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sym_reg   <= res_rdata;
                        out_last_reg  <= (idx_reg == '0);
                        out_empty_reg <= 1'b0;
                        out_ovf_reg   <= ovf_reg;
                        if (idx_reg == '0)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - RES_AW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end

                S_EMPTY:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sym_reg   <= '0;
                        out_last_reg  <= 1'b1;
                        out_empty_reg <= 1'b1;
                        out_ovf_reg   <= ovf_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign symbol_out = out_sym_reg;
    assign last       = out_last_reg;
    assign empty_res  = out_empty_reg;
    assign overflow   = out_ovf_reg;

    // first string buffer
    scs_str_mem #(
        .DEPTH (MAX_LEN),
        .AW    (STR_AW)
    ) u_str_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (symbol),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // second string buffer
    scs_str_mem #(
        .DEPTH (MAX_LEN),
        .AW    (STR_AW)
    ) u_str_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (symbol),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // score table
    scs_lcs_mem #(
        .DEPTH (LCS_DEP),
        .AW    (LCS_AW),
        .DW    (VAL_W)
    ) u_lcs (
        .clk    (clk),
        .we     (lcs_we),
        .waddr  (lcs_waddr),
        .wdata  (lcs_wdata),
        .raddr0 (lcs_raddr0),
        .rdata0 (lcs_rdata0),
        .raddr1 (lcs_raddr1),
        .rdata1 (lcs_rdata1)
    );

    // traceback buffer, written at k and read back from k-1 down
    scs_res_mem #(
        .DEPTH (RES_DEP),
        .AW    (RES_AW)
    ) u_res (
        .clk   (clk),
        .we    (res_we),
        .waddr (k_reg[RES_AW-1:0]),
        .wdata (res_wdata),
        .raddr (idx_reg),
        .rdata (res_rdata)
    );

endmodule

// ----- sv/scs_checker.sv -----
// port-level checks for the supersequence block, bound to its top level
// depends on scs_pkg, assert_macros.svh, shortest_common_supersequence
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [scs_pkg::CMD_W-1:0]  command,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [scs_pkg::SYM_W-1:0]  symbol_out,
    input logic                       last,
    input logic                       empty_res
);
    import scs_pkg::*;

    // a stalled result item holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(symbol_out) && $stable(last) && $stable(empty_res))

    // an empty result is always a final item with a zero symbol
    `ASSERT_IMPLIES(a_empty_last, clk, rst_n, out_valid && empty_res, last && (symbol_out == '0))

    // a compute item holds off the input for at least the next cycle
    `ASSERT_NEXT(a_compute_busy, clk, rst_n, in_valid && !in_stall && (command == CMD_COMPUTE), in_stall)

endmodule

bind shortest_common_supersequence scs_checker u_scs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol_out (symbol_out),
    .last       (last),
    .empty_res  (empty_res)
);

// ----- tb/shortest_common_supersequence_tb.sv -----
// testbench for the shortest common supersequence block: loads, computes and result checks
// depends on scs_pkg and shortest_common_supersequence; holds its own supersequence predictor
`timescale 1ns / 1ps

module shortest_common_supersequence_tb;

    import scs_pkg::*;

    // command code the block has no meaning for; it must be ignored
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
    localparam int STR_MAX = MAX_LEN_DEF;

    // one expected result item
    typedef struct {
        sym_t sym;
        logic is_last;
        logic is_empty;
        logic ovf;
    } scs_result_t;

    // keeps a copy of both strings and the drop mark, and the results still to come
    class scs_scoreboard;
        sym_t        first_str[$];
        sym_t        second_str[$];
        logic        dropped;
        scs_result_t awaited[$];
        int          mismatches;

        function new();
            dropped    = 1'b0;
            mismatches = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // lcs table, traceback from the far corner, then queue the symbols first to last
        function void predict_supersequence();
            int   n;
            int   m;
            int   r;
            int   c;
            int   score [0:STR_MAX][0:STR_MAX];
            sym_t rev[$];
            n = first_str.size();
            m = second_str.size();
            if (n == 0 && m == 0) begin
                awaited.insert(awaited.size(),
                               '{sym: '0, is_last: 1'b1, is_empty: 1'b1, ovf: dropped});
            end
            else begin
                for (r = 0; r <= n; r++) begin
                    for (c = 0; c <= m; c++) begin
                        if (r == 0 || c == 0)
                            score[r][c] = 0;
                        else if (first_str[r-1] == second_str[c-1])
                            score[r][c] = score[r-1][c-1] + 1;
                        else
                            score[r][c] = (score[r-1][c] > score[r][c-1]) ?
                                          score[r-1][c] : score[r][c-1];
                    end
                end
                r = n;
                c = m;
                while (r > 0 && c > 0) begin
                    if (first_str[r-1] == second_str[c-1]) begin
                        rev.insert(rev.size(), first_str[r-1]);
                        r--;
                        c--;
                    end
                    else if (score[r-1][c] > score[r][c-1]) begin
                        rev.insert(rev.size(), first_str[r-1]);
                        r--;
                    end
                    else begin
                        rev.insert(rev.size(), second_str[c-1]);
                        c--;
                    end
                end
                while (r > 0) begin
                    rev.insert(rev.size(), first_str[r-1]);
                    r--;
                end
                while (c > 0) begin
                    rev.insert(rev.size(), second_str[c-1]);
                    c--;
                end
                for (int i = rev.size() - 1; i >= 0; i--)
                    awaited.insert(awaited.size(),
                                   '{sym: rev[i], is_last: (i == 0), is_empty: 1'b0,
                                     ovf: dropped});
            end
            first_str.delete();
            second_str.delete();
            dropped = 1'b0;
        endfunction

        // called for every accepted input item
        function void note_item(input logic [CMD_W-1:0] cmd, input sym_t sym);
            case (cmd)
                CMD_LOAD_A:
                    if (first_str.size() < STR_MAX) first_str.insert(first_str.size(), sym);
                    else dropped = 1'b1;
                CMD_LOAD_B:
                    if (second_str.size() < STR_MAX) second_str.insert(second_str.size(), sym);
                    else dropped = 1'b1;
                CMD_COMPUTE:
                    predict_supersequence();
                default: ;
            endcase
        endfunction

        // called for every accepted result item
        task check_result(input sym_t sym, input logic lst, input logic emp, input logic ovf);
            scs_result_t exp_r;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result %02h with nothing awaited", sym));
            end
            else begin
                exp_r = awaited.pop_front();
                if (!exp_r.is_empty && sym !== exp_r.sym)
                    report_mismatch($sformatf("symbol_out %02h, awaited %02h", sym, exp_r.sym));
                if (lst !== exp_r.is_last)
                    report_mismatch($sformatf("last %b, awaited %b", lst, exp_r.is_last));
                if (emp !== exp_r.is_empty)
                    report_mismatch($sformatf("empty_res %b, awaited %b", emp, exp_r.is_empty));
                if (ovf !== exp_r.ovf)
                    report_mismatch($sformatf("overflow %b, awaited %b", ovf, exp_r.ovf));
            end
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [CMD_W-1:0] command;
    logic [SYM_W-1:0] symbol;
    logic             out_valid;
    logic             out_stall;
    logic [SYM_W-1:0] symbol_out;
    logic             last;
    logic             empty_res;
    logic             overflow;

    scs_scoreboard sb = new();

    // idle percentages of the current phase
    int send_idle = 0;
    int recv_idle = 0;
    // cycles the receiver still holds off regardless of recv_idle
    int hold_left = 0;
    // load and compute items sent so far; ignored commands are not counted
    int items_sent = 0;

    shortest_common_supersequence u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .symbol     (symbol),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .symbol_out (symbol_out),
        .last       (last),
        .empty_res  (empty_res),
        .overflow   (overflow)
    );

    // 8 ns period
    always #4 clk = ~clk;

    // all signals change on nonblocking updates, so these see pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_item(command, symbol);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(symbol_out, last, empty_res, overflow);
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else begin
                out_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    // offer one item after a random gap and wait until it is taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input sym_t sym);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        symbol   <= sym;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd != CMD_IGNORED)
            items_sent++;
    endtask

    // one well-formed pair of strings, loads interleaved at random, then a compute
    task automatic send_string_pair(input int n, input int m, input bit narrow);
        int   left_a;
        int   left_b;
        sym_t base;
        sym_t sym;
        left_a = n;
        left_b = m;
        base   = sym_t'($urandom_range(0, 252));
        while (left_a + left_b > 0)
        begin
            // a narrow alphabet makes matches, and so real lcs paths, common
            sym = narrow ? sym_t'(base + $urandom_range(0, 3)) : sym_t'($urandom_range(0, 255));
            // occasional noise the block must ignore
            if ($urandom_range(99) < 4)
                send_item(CMD_IGNORED, sym_t'($urandom_range(0, 255)));
            if (left_b == 0 || (left_a > 0 && $urandom_range(1) == 0)) begin
                send_item(CMD_LOAD_A, sym);
                left_a--;
            end
            else begin
                send_item(CMD_LOAD_B, sym);
                left_b--;
            end
        end
        send_item(CMD_COMPUTE, sym_t'($urandom_range(0, 255)));
    endtask

    // mostly short strings; a few near or past capacity to reach the drop path
    task automatic random_pairs(input int target);
        int  sel;
        int  n;
        int  m;
        while (items_sent < target)
        begin
            sel = $urandom_range(99);
            if (sel < 6) begin
                n = $urandom_range(28, STR_MAX + 2);
                m = $urandom_range(28, STR_MAX + 2);
            end
            else begin
                n = $urandom_range(0, 7);
                m = $urandom_range(0, 7);
            end
            send_string_pair(n, m, ($urandom_range(99) < 60));
        end
    endtask

    // hard stop if the block hangs
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        command  = CMD_LOAD_A;
        symbol   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, receiver and sender without gaps
        // both strings empty gives the single empty item
        send_item(CMD_COMPUTE, 8'h00);
        // unknown command, no result
        send_item(CMD_IGNORED, 8'hff);
        // symbol extremes, tie at the corner
        send_item(CMD_LOAD_A, 8'h00);
        send_item(CMD_LOAD_A, 8'hff);
        send_item(CMD_LOAD_B, 8'hff);
        send_item(CMD_LOAD_B, 8'h00);
        send_item(CMD_COMPUTE, 8'hff);
        // only the first string: all leftovers
        send_item(CMD_LOAD_A, 8'h5a);
        send_item(CMD_COMPUTE, 8'h00);
        // only the second string
        send_item(CMD_LOAD_B, 8'ha5);
        send_item(CMD_COMPUTE, 8'h00);
        // cell above larger than cell to the left, first string taken
        send_item(CMD_LOAD_A, 8'h62);
        send_item(CMD_LOAD_A, 8'h61);
        send_item(CMD_LOAD_B, 8'h62);
        send_item(CMD_COMPUTE, 8'h00);
        // mixed matches and mismatches
        send_item(CMD_LOAD_A, 8'h61);
        send_item(CMD_LOAD_A, 8'h62);
        send_item(CMD_LOAD_A, 8'h63);
        send_item(CMD_LOAD_B, 8'h61);
        send_item(CMD_LOAD_B, 8'h63);
        send_item(CMD_COMPUTE, 8'h00);

        // sender idles more rarely than the receiver
        send_idle = 28;
        recv_idle = 58;
        random_pairs(160);

        // and the other way round
        send_idle = 58;
        recv_idle = 28;
        random_pairs(300);

        // no idling; first a long hold-off on the output while items keep coming
        send_idle = 0;
        recv_idle = 0;
        hold_left = 400;
        send_string_pair(6, 5, 1'b1);
        send_string_pair(4, 7, 1'b1);
        random_pairs(400);

        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        // room for any stray result
        repeat (200) @(posedge clk);

        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/scs_pkg.sv
sv/scs_str_mem.sv
sv/scs_lcs_mem.sv
sv/scs_res_mem.sv
sv/shortest_common_supersequence.sv
sv/scs_checker.sv
tb/shortest_common_supersequence_tb.sv
